/* rtl/pnf_pkg.sv */
// ----------------------------------------------------------------------------
// pnf_pkg: shared types and constants for the partitioned next-fit allocator
// Slot store geometry, operation and status codes, control structs.
// ----------------------------------------------------------------------------
package pnf_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int ID_WIDTH   = 16;
  localparam int FIELD_ID_W = 16;
  localparam int BOUND_W    = 8;
  localparam int RES_W      = 9;

  localparam logic [BOUND_W-1:0] RST_POOL1_START = 8'd40;
  localparam logic [BOUND_W-1:0] RST_POOL2_START = 8'd90;
  localparam logic [BOUND_W-1:0] RST_POOL3_START = 8'd190;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_LOOKUP  = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_NONE    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;

  localparam logic [1:0] CFG_POOL1_START = 2'd0;
  localparam logic [1:0] CFG_POOL2_START = 2'd1;
  localparam logic [1:0] CFG_POOL3_START = 2'd2;

  typedef struct packed {
    logic [2:0][BOUND_W-1:0] bound;
    logic [3:0][SLOT_W-1:0]  next;
  } pool_cfg_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        pool;
    logic [SLOT_W-1:0] slot;
  } ptr_wr_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic                re;
    logic [SLOT_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [RES_W-1:0] slot_number;
    logic [RES_W-1:0] freed_count;
    logic [1:0]       status;
  } result_t;

endpackage

/* rtl/pnf_if.sv */
// ----------------------------------------------------------------------------
// pnf_if: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pnf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  pool;
  logic [15:0] owner_id;

  modport source (output valid, output func, output pool, output owner_id, input ready);
  modport sink   (input valid, input func, input pool, input owner_id, output ready);
endinterface

interface pnf_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] slot_number;
  logic [8:0] freed_count;
  logic [1:0] status;

  modport source (output valid, output slot_number, output freed_count, output status,
                  input ready);
  modport sink   (input valid, input slot_number, input freed_count, input status,
                  output ready);
endinterface

/* rtl/pnf_ram.sv */
// ----------------------------------------------------------------------------
// pnf_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pnf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pnf_ctrl.sv */
// ----------------------------------------------------------------------------
// pnf_ctrl: scan sequencer
// Clears the store after reset, then runs allocate, lookup and release as
// pipelined read/check/write-back scans over the slot store.
// ----------------------------------------------------------------------------
module pnf_ctrl
  import pnf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  pnf_in_if.sink              in_word,
  input  pool_cfg_t           cfg,
  output ptr_wr_t             ptr_wr,
  output mem_req_t            mem_req,
  input  logic [ID_WIDTH-1:0] rd_data,
  output result_t             res,
  output logic                res_valid,
  input  logic                res_ready
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0]   chk_addr_r, chk_addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [1:0]          pool_r, pool_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  result_t             res_r, res_nxt;

  logic [ID_WIDTH-1:0] in_id;
  logic [CNT_W-1:0]    pool_lo, pool_hi, pool_ptr, pool_start;
  logic [CNT_W-1:0]    addr_inc;
  logic                stop;

  function automatic logic [CNT_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
    if (int'(b) > SLOT_COUNT) begin
      return CNT_W'(SLOT_COUNT);
    end
    return CNT_W'(b);
  endfunction

  assign in_id         = in_word.owner_id[ID_WIDTH-1:0];
  assign in_word.ready = (state_r == S_IDLE);
  assign res           = res_r;
  assign res_valid     = (state_r == S_DONE);

  // pool window of the requested pool
  always_comb begin
    pool_lo  = (in_word.pool == 2'd0) ? '0 : clamp_bound(cfg.bound[in_word.pool - 2'd1]);
    pool_hi  = (in_word.pool == 2'd3) ? CNT_W'(SLOT_COUNT) : clamp_bound(cfg.bound[in_word.pool]);
    pool_ptr = {1'b0, cfg.next[in_word.pool]};
    pool_start = (pool_ptr < pool_lo || pool_ptr >= pool_hi) ? pool_lo : pool_ptr;
  end

  assign addr_inc = {1'b0, addr_r} + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    chk_v_nxt    = 1'b0;
    chk_addr_nxt = chk_addr_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    func_nxt     = func_r;
    pool_nxt     = pool_r;
    id_nxt       = id_r;
    res_nxt      = res_r;
    ptr_wr       = '0;
    mem_req      = '0;
    stop         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_r;
        mem_req.wdata = '0;
        addr_nxt      = addr_inc[SLOT_W-1:0];
        if (addr_inc == CNT_W'(SLOT_COUNT)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_word.valid) begin
          func_nxt = in_word.func;
          pool_nxt = in_word.pool;
          id_nxt   = in_id;
          cnt_nxt  = '0;
          if (in_word.func == FN_NONE) begin
            res_nxt   = '{slot_number: '0, freed_count: '0, status: ST_OK};
            state_nxt = S_DONE;
          end else if (in_id == '0) begin
            res_nxt   = '{slot_number: '0, freed_count: '0, status: ST_BAD_ID};
            state_nxt = S_DONE;
          end else if (in_word.func == FN_ALLOC) begin
            lo_nxt    = pool_lo;
            hi_nxt    = pool_hi;
            addr_nxt  = pool_start[SLOT_W-1:0];
            left_nxt  = (pool_hi > pool_lo) ? pool_hi - pool_lo : '0;
            state_nxt = S_SCAN;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = CNT_W'(SLOT_COUNT);
            addr_nxt  = '0;
            left_nxt  = CNT_W'(SLOT_COUNT);
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // check the word read last cycle
        if (chk_v_r) begin
          case (func_r)
            FN_ALLOC: begin
              if (rd_data == '0) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = chk_addr_r;
                mem_req.wdata = id_r;
                ptr_wr.en     = 1'b1;
                ptr_wr.pool   = pool_r;
                ptr_wr.slot   = chk_addr_r;
                res_nxt       = '{slot_number: RES_W'({1'b0, chk_addr_r} + CNT_W'(1)),
                                  freed_count: '0, status: ST_OK};
                stop          = 1'b1;
              end
            end
            FN_LOOKUP: begin
              if (rd_data == id_r) begin
                res_nxt = '{slot_number: RES_W'({1'b0, chk_addr_r} + CNT_W'(1)),
                            freed_count: '0, status: ST_OK};
                stop    = 1'b1;
              end
            end
            default: begin
              if (rd_data == id_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = chk_addr_r;
                mem_req.wdata = '0;
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
          endcase
        end

        if (stop) begin
          state_nxt = S_DONE;
        end else if (left_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = addr_r;
          chk_v_nxt     = 1'b1;
          chk_addr_nxt  = addr_r;
          left_nxt      = left_r - CNT_W'(1);
          // next-fit wrap from pool end back to pool start
          addr_nxt      = (addr_inc == hi_r) ? lo_r[SLOT_W-1:0] : addr_inc[SLOT_W-1:0];
        end else if (!chk_v_r) begin
          state_nxt = S_DONE;
          if (func_r == FN_RELEASE) begin
            res_nxt = '{slot_number: '0, freed_count: RES_W'(cnt_r),
                        status: (cnt_r == '0) ? ST_MISS : ST_OK};
          end else begin
            res_nxt = '{slot_number: '0, freed_count: '0, status: ST_MISS};
          end
        end
      end

      default: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    chk_addr_r <= chk_addr_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    func_r     <= func_nxt;
    pool_r     <= pool_nxt;
    id_r       <= id_nxt;
    res_r      <= res_nxt;
  end

endmodule

/* rtl/partitioned_next_fit_slot_allocator.sv */
// ----------------------------------------------------------------------------
// partitioned_next_fit_slot_allocator: four-pool next-fit slot allocator
// Owner-id slot store with boundary registers, pool pointers and result reg.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries one request word (func, pool, owner_id); out_word returns
//   one result word (slot_number, freed_count, status) per request. The cfg
//   port writes the three pool boundaries; write them only while idle.
//   One request is worked on at a time. Each scan reads the slot store one
//   slot per cycle through its single read port, checks the word in the next
//   cycle and writes back in place. Release and a lookup miss scan the whole
//   store. A lookup hit or an allocate stops at the first matching slot; an
//   allocate in a full pool scans the whole pool. An invalid id or the unused
//   function code answers without a scan. The next request is taken once the
//   result has left the sequencer.
//   After reset every slot of the store is cleared to zero; no request
//   is taken during that pass, cfg writes are taken as ever.
//   The result sits in an output register: a stalled receiver holds it there
//   while the next request is accepted and worked on; that request's result
//   waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module partitioned_next_fit_slot_allocator
  import pnf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  pnf_in_if.sink             in_word,
  pnf_out_if.source          out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [BOUND_W-1:0] cfg_wdata
);

  logic [2:0][BOUND_W-1:0] bound_r, bound_nxt;
  logic [3:0][SLOT_W-1:0]  next_r, next_nxt;
  logic                    ov_r, ov_nxt;
  result_t                 ores_r;

  pool_cfg_t           cfg;
  ptr_wr_t             ptr_wr;
  mem_req_t            mem_req;
  logic [ID_WIDTH-1:0] rd_data;
  result_t             res;
  logic                res_valid;
  logic                res_take;

  assign cfg.bound = bound_r;
  assign cfg.next  = next_r;

  pnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg       (cfg),
    .ptr_wr    (ptr_wr),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_take)
  );

  pnf_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (ID_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  always_comb begin
    bound_nxt = bound_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POOL1_START: bound_nxt[0] = cfg_wdata;
        CFG_POOL2_START: bound_nxt[1] = cfg_wdata;
        CFG_POOL3_START: bound_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    next_nxt = next_r;
    if (ptr_wr.en) begin
      next_nxt[ptr_wr.pool] = ptr_wr.slot;
    end
  end

  // output register loads when empty or being drained
  assign res_take = res_valid && (!ov_r || out_word.ready);

  always_comb begin
    ov_nxt = ov_r;
    if (res_take) begin
      ov_nxt = 1'b1;
    end else if (out_word.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= {RST_POOL3_START, RST_POOL2_START, RST_POOL1_START};
      next_r  <= {SLOT_W'(RST_POOL3_START), SLOT_W'(RST_POOL2_START),
                  SLOT_W'(RST_POOL1_START), SLOT_W'(0)};
      ov_r    <= 1'b0;
    end else begin
      bound_r <= bound_nxt;
      next_r  <= next_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      ores_r <= res;
    end
  end

  assign out_word.valid       = ov_r;
  assign out_word.slot_number = ores_r.slot_number;
  assign out_word.freed_count = ores_r.freed_count;
  assign out_word.status      = ores_r.status;

  // write-back never lands on the slot being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("store read and write collide on one slot");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> !in_word.ready)
    else $error("request accepted while another is in flight");

  // a failed request never reports a slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.status != ST_OK |-> out_word.slot_number == '0)
    else $error("error status with nonzero slot number");

  // pointer moves only to a slot that was just written
  a_ptr_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_wr.en |-> mem_req.we && mem_req.waddr == ptr_wr.slot && mem_req.wdata != '0)
    else $error("pool pointer moved without an allocation");

endmodule
